### src/dpq_pkg.sv
// Package for the double-ended priority queue: operation and status codes,
// and the control struct that goes from the top level to the sorted cells.
// No dependencies.
package dpq_pkg;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_POP_MAX = 2'd1,
        OP_POP_MIN = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic insert;   // insert the new entry, cells at and above it shift up
        logic pop_min;  // every cell takes its upper neighbour
    } cell_ctrl_t;

endpackage

### src/dpq_if.sv
// Valid/ready channel interfaces for the queue: request items in, result items out.
// Depends on nothing but the widths given as parameters.
interface dpq_req_if #(
    parameter int ID_BITS       = 20,
    parameter int PRIORITY_BITS = 24
);
    logic                     valid;
    logic                     ready;
    logic [1:0]               opcode;
    logic [ID_BITS-1:0]       entry_id;
    logic [PRIORITY_BITS-1:0] priority_req;

    modport source (output valid, output opcode, output entry_id, output priority_req,
                    input ready);
    modport sink   (input valid, input opcode, input entry_id, input priority_req,
                    output ready);
endinterface

interface dpq_rsp_if #(
    parameter int ID_BITS = 20
);
    logic               valid;
    logic               ready;
    logic [ID_BITS-1:0] popped_id;
    logic [1:0]         status;

    modport source (output valid, output popped_id, output status, input ready);
    modport sink   (input valid, input popped_id, input status, output ready);
endinterface

### src/dpq_cell.sv
// One slot of the sorted register array: holds an id and its priority and
// picks its next value from itself, its neighbours or the new entry.
// Depends on dpq_pkg.
module dpq_cell #(
    parameter int ID_BITS       = 20,
    parameter int PRIORITY_BITS = 24,
    parameter int CNT_W         = 7,
    parameter int INDEX         = 0
) (
    input  logic                     clk,
    input  dpq_pkg::cell_ctrl_t      ctrl,
    input  logic [CNT_W-1:0]         count,
    input  logic [ID_BITS-1:0]       new_id,
    input  logic [PRIORITY_BITS-1:0] new_prio,
    input  logic                     lower_gt,
    input  logic [ID_BITS-1:0]       lower_id,
    input  logic [PRIORITY_BITS-1:0] lower_prio,
    input  logic [ID_BITS-1:0]       upper_id,
    input  logic [PRIORITY_BITS-1:0] upper_prio,
    output logic                     gt,
    output logic [ID_BITS-1:0]       id,
    output logic [PRIORITY_BITS-1:0] prio
);

    logic [ID_BITS-1:0]       id_reg;
    logic [ID_BITS-1:0]       id_next;
    logic [PRIORITY_BITS-1:0] prio_reg;
    logic [PRIORITY_BITS-1:0] prio_next;

    // empty slots count as greater than anything
    assign gt   = (count <= CNT_W'(INDEX)) || (prio_reg > new_prio);
    assign id   = id_reg;
    assign prio = prio_reg;

    always_comb
    begin
        id_next   = id_reg;
        prio_next = prio_reg;
        priority if (ctrl.insert && lower_gt)
        begin
            id_next   = lower_id;
            prio_next = lower_prio;
        end
        else if (ctrl.insert && gt)
        begin
            id_next   = new_id;
            prio_next = new_prio;
        end
        else if (ctrl.pop_min)
        begin
            id_next   = upper_id;
            prio_next = upper_prio;
        end
        else
        begin
            id_next   = id_reg;
            prio_next = prio_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

endmodule

### src/double_ended_priority_queue_core.sv
// Double-ended priority queue on a sorted register array.
// Each result item is registered in the cycle after its request item is accepted.
// Throughput: one item per cycle while the result side is ready; the cell compares all run in parallel.
// Reset: asynchronous, active low; clears the entry count and the result valid,
// slot contents stay undefined until written. No clearing pass.
module double_ended_priority_queue_core #(
    parameter int CAPACITY      = 64,
    parameter int ID_BITS       = 20,
    parameter int PRIORITY_BITS = 24
) (
    input  logic      clk,
    input  logic      rst_n,
    dpq_req_if.sink   req,
    dpq_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    logic [ID_BITS-1:0]       rsp_id_reg;
    logic [ID_BITS-1:0]       rsp_id_next;
    dpq_pkg::status_t         rsp_status_reg;
    dpq_pkg::status_t         rsp_status_next;

    logic                     accept;
    logic                     is_empty;
    logic                     is_full;
    dpq_pkg::opcode_t         op;
    dpq_pkg::cell_ctrl_t      ctrl;

    logic [CAPACITY-1:0]      gt;
    logic [ID_BITS-1:0]       cell_id   [CAPACITY];
    logic [PRIORITY_BITS-1:0] cell_prio [CAPACITY];
    logic [ID_BITS-1:0]       top_id;

    assign req.ready     = !rsp_valid_reg || rsp.ready;
    assign accept        = req.valid && req.ready;
    assign is_empty      = (count_reg == '0);
    assign is_full       = (count_reg == CNT_W'(CAPACITY));
    assign op            = dpq_pkg::opcode_t'(req.opcode);

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.popped_id = rsp_id_reg;
    assign rsp.status    = rsp_status_reg;

    always_comb
    begin
        ctrl.insert  = accept && (op == dpq_pkg::OP_INSERT) && !is_full;
        ctrl.pop_min = accept && (op == dpq_pkg::OP_POP_MIN) && !is_empty;
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                     lower_gt;
            logic [ID_BITS-1:0]       lower_id;
            logic [PRIORITY_BITS-1:0] lower_prio;
            logic [ID_BITS-1:0]       upper_id;
            logic [PRIORITY_BITS-1:0] upper_prio;

            if (i == 0)
            begin : g_bottom
                assign lower_gt   = 1'b0;
                assign lower_id   = req.entry_id;
                assign lower_prio = req.priority_req;
            end
            else
            begin : g_mid_lo
                assign lower_gt   = gt[i-1];
                assign lower_id   = cell_id[i-1];
                assign lower_prio = cell_prio[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_top
                assign upper_id   = cell_id[i];
                assign upper_prio = cell_prio[i];
            end
            else
            begin : g_mid_hi
                assign upper_id   = cell_id[i+1];
                assign upper_prio = cell_prio[i+1];
            end

            dpq_cell #(
                .ID_BITS       (ID_BITS),
                .PRIORITY_BITS (PRIORITY_BITS),
                .CNT_W         (CNT_W),
                .INDEX         (i)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .count      (count_reg),
                .new_id     (req.entry_id),
                .new_prio   (req.priority_req),
                .lower_gt   (lower_gt),
                .lower_id   (lower_id),
                .lower_prio (lower_prio),
                .upper_id   (upper_id),
                .upper_prio (upper_prio),
                .gt         (gt[i]),
                .id         (cell_id[i]),
                .prio       (cell_prio[i])
            );
        end
    endgenerate

    // highest occupied slot, one-hot select
    always_comb
    begin
        top_id = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (count_reg == CNT_W'(k + 1))
            begin
                top_id = top_id | cell_id[k];
            end
        end
    end

    always_comb
    begin
        count_next      = count_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_id_next     = rsp_id_reg;
        rsp_status_next = rsp_status_reg;
        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (accept)
        begin
            rsp_valid_next  = 1'b1;
            rsp_id_next     = '0;
            rsp_status_next = dpq_pkg::ST_OK;
            unique case (op)
                dpq_pkg::OP_INSERT:
                begin
                    if (is_full)
                    begin
                        rsp_status_next = dpq_pkg::ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                dpq_pkg::OP_POP_MAX:
                begin
                    if (is_empty)
                    begin
                        rsp_status_next = dpq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        rsp_id_next = top_id;
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
                dpq_pkg::OP_POP_MIN:
                begin
                    if (is_empty)
                    begin
                        rsp_status_next = dpq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        rsp_id_next = cell_id[0];
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    rsp_status_next = dpq_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_id_reg     <= rsp_id_next;
        rsp_status_reg <= rsp_status_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == dpq_pkg::OP_INSERT && is_full)
        |=> (rsp_status_reg == dpq_pkg::ST_FULL) && $stable(count_reg))
        else $error("insert on full queue not dropped");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == dpq_pkg::OP_POP_MAX || op == dpq_pkg::OP_POP_MIN) && is_empty)
        |=> (rsp_status_reg == dpq_pkg::ST_EMPTY) && (rsp_id_reg == '0))
        else $error("pop on empty queue misreported");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.pop_min) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("pop did not decrement count");

    a_sorted_low: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> (cell_prio[0] <= cell_prio[1]))
        else $error("lowest slots out of order");

endmodule
